// ----- rtl/time_of_day_clock_with_alarm_core_assert.svh -----
// Assertion macros for the time-of-day clock core checker
// Depends on nothing; included by the checker file only
`ifndef TIME_OF_DAY_CLOCK_WITH_ALARM_CORE_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_WITH_ALARM_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TOD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tod_pkg.sv -----
// Shared types, constants and helpers for the time-of-day clock core
// Used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

  // request kinds
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET_TIME = 2'd1,
    REQ_SET_ALRM = 2'd2,
    REQ_BUTTON   = 2'd3
  } tod_req_e;

  // limits of the time fields
  localparam logic [7:0] HoursPerDay = 8'd24;
  localparam logic [7:0] MinsPerHour = 8'd60;
  localparam logic [7:0] SecsPerMin  = 8'd60;
  localparam logic [4:0] HalfDay     = 5'd12;
  localparam logic [4:0] LastHour    = 5'd23;
  localparam logic [5:0] LastMinute  = 6'd59;
  localparam logic [5:0] LastSecond  = 6'd59;

  // reset values of the alarm setting
  localparam logic [4:0] AlarmHourRst   = 5'd7;
  localparam logic [5:0] AlarmMinuteRst = 6'd0;

  // one input transaction
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] new_hour;
    logic [7:0] new_minute;
    logic [7:0] new_second;
    logic       button_pressed;
  } tod_req_t;

  // one result transaction
  typedef struct packed {
    logic [3:0]  show_hour12;
    logic        is_pm;
    logic [4:0]  show_hour24;
    logic [5:0]  show_minute;
    logic [5:0]  show_second;
    logic        alarm_led;
    logic        alarm_armed;
    logic        alarm_fired;
    logic [31:0] set_count;
  } tod_res_t;

  // 24-hour value to 12-hour dial, midnight shows as 12
  function automatic logic [3:0] to_hour12(input logic [4:0] hour24);
    logic [4:0] diff;
    diff = hour24 - HalfDay;
    if (hour24 == 5'd0) begin
      return HalfDay[3:0];
    end else if (hour24 <= HalfDay) begin
      return hour24[3:0];
    end else begin
      return diff[3:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tod_in_stage.sv -----
// Input register of the time-of-day clock core
// Holds one request until the time state can take it; uses tod_pkg
`timescale 1ns / 1ps
`default_nettype none

module tod_in_stage
  import tod_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire tod_req_t in_req_i,
  input  wire logic     advance_i,
  output logic          valid_o,
  output tod_req_t      req_o
);

  logic     valid_q, valid_d;
  tod_req_t req_q;
  logic     load;

  // accept a transaction when the register is empty or draining this cycle
  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

// ----- rtl/tod_time_state.sv -----
// Clock, alarm and set-counter state of the time-of-day clock core
// Applies one request per cycle while fire_i is high and forms its result; uses tod_pkg
`timescale 1ns / 1ps
`default_nettype none

module tod_time_state
  import tod_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire tod_req_t req_i,
  output tod_res_t      res_o
);

  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [4:0]  alm_hour_q, alm_hour_d;
  logic [5:0]  alm_min_q, alm_min_d;
  logic        armed_q, armed_d;
  logic        fired_q, fired_d;
  logic        led_q, led_d;
  logic [31:0] set_cnt_q, set_cnt_d;

  logic        sec_wrap, min_wrap;
  logic [4:0]  tick_hour;
  logic [5:0]  tick_min, tick_sec;
  logic        alarm_hit;
  logic [4:0]  in_hour;
  logic [5:0]  in_min, in_sec;

  // one-second advance with carries
  assign sec_wrap  = (sec_q == LastSecond);
  assign min_wrap  = sec_wrap & (min_q == LastMinute);
  assign tick_sec  = sec_wrap ? 6'd0 : sec_q + 6'd1;
  assign tick_min  = sec_wrap ? ((min_q == LastMinute) ? 6'd0 : min_q + 6'd1) : min_q;
  assign tick_hour = min_wrap ? ((hour_q == LastHour) ? 5'd0 : hour_q + 5'd1) : hour_q;
  assign alarm_hit = armed_q & ~fired_q & (tick_hour == alm_hour_q) &
                     (tick_min == alm_min_q);

  // out-of-range set values fall back to zero
  assign in_hour = (req_i.new_hour < HoursPerDay) ? req_i.new_hour[4:0] : 5'd0;
  assign in_min  = (req_i.new_minute < MinsPerHour) ? req_i.new_minute[5:0] : 6'd0;
  assign in_sec  = (req_i.new_second < SecsPerMin) ? req_i.new_second[5:0] : 6'd0;

  // next state per request kind
  always_comb begin
    hour_d     = hour_q;
    min_d      = min_q;
    sec_d      = sec_q;
    alm_hour_d = alm_hour_q;
    alm_min_d  = alm_min_q;
    armed_d    = armed_q;
    fired_d    = fired_q;
    led_d      = led_q;
    set_cnt_d  = set_cnt_q;
    if (fire_i) begin
      unique case (req_i.req_type)
        REQ_TICK: begin
          hour_d = tick_hour;
          min_d  = tick_min;
          sec_d  = tick_sec;
          if (alarm_hit) begin
            led_d   = 1'b1;
            fired_d = 1'b1;
          end
        end
        REQ_SET_TIME: begin
          hour_d    = in_hour;
          min_d     = in_min;
          sec_d     = in_sec;
          set_cnt_d = set_cnt_q + 32'd1;
        end
        REQ_SET_ALRM: begin
          alm_hour_d = in_hour;
          alm_min_d  = in_min;
          armed_d    = 1'b1;
          fired_d    = 1'b0;
          led_d      = 1'b0;
        end
        REQ_BUTTON: begin
          if (req_i.button_pressed) begin
            led_d = 1'b0;
          end
        end
        default: begin
          led_d = led_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q     <= 5'd0;
      min_q      <= 6'd0;
      sec_q      <= 6'd0;
      alm_hour_q <= AlarmHourRst;
      alm_min_q  <= AlarmMinuteRst;
      armed_q    <= 1'b0;
      fired_q    <= 1'b0;
      led_q      <= 1'b0;
      set_cnt_q  <= 32'd0;
    end else begin
      hour_q     <= hour_d;
      min_q      <= min_d;
      sec_q      <= sec_d;
      alm_hour_q <= alm_hour_d;
      alm_min_q  <= alm_min_d;
      armed_q    <= armed_d;
      fired_q    <= fired_d;
      led_q      <= led_d;
      set_cnt_q  <= set_cnt_d;
    end
  end

  // result shows the state after the request
  always_comb begin
    res_o.show_hour12 = to_hour12(hour_d);
    res_o.is_pm       = (hour_d >= HalfDay);
    res_o.show_hour24 = hour_d;
    res_o.show_minute = min_d;
    res_o.show_second = sec_d;
    res_o.alarm_led   = led_d;
    res_o.alarm_armed = armed_d;
    res_o.alarm_fired = fired_d;
    res_o.set_count   = set_cnt_d;
  end

endmodule

`default_nettype wire

// ----- rtl/tod_out_stage.sv -----
// Result register of the time-of-day clock core
// Holds one result until the consumer takes it; uses tod_pkg
`timescale 1ns / 1ps
`default_nettype none

module tod_out_stage
  import tod_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire tod_res_t res_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output tod_res_t      out_res_o
);

  logic     valid_q, valid_d;
  tod_res_t res_q;

  // free when empty or when the held result leaves this cycle
  assign ready_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

// ----- rtl/time_of_day_clock_with_alarm_core.sv -----
// Top level of the time-of-day clock core with one-shot alarm
// Instantiates tod_in_stage, tod_time_state and tod_out_stage; uses tod_pkg
`timescale 1ns / 1ps
`default_nettype none

// Each request (tick, set time, set alarm, button sample) gives exactly one result
// transaction: the 12/24-hour time, alarm LED, armed and fired flags and the set-time
// count as they stand after the request. A request is first registered in the input
// register at acceptance, then applied to the clock state when the result register
// loads its result, which the result register then offers until it is taken. One
// request per clock is sustained while out_stall_i stays low; the throughput is set
// by the single state update between the input register and the result register.
// Stall on the output holds the result register and then the input register before
// in_stall_o rises.

module time_of_day_clock_with_alarm_core
  import tod_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire tod_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output tod_res_t      out_res_o
);

  logic     req_valid;
  tod_req_t req;
  logic     out_ready;
  logic     fire;
  tod_res_t res_next;

  // a request moves into the state when the result register can take its result
  assign fire = req_valid & out_ready;

  tod_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .advance_i  (fire),
    .valid_o    (req_valid),
    .req_o      (req)
  );

  tod_time_state u_time_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req),
    .res_o  (res_next)
  );

  tod_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res_next),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

// ----- rtl/tod_checker.sv -----
// Port-level checker for the time-of-day clock core, bound to the top level
// Uses tod_pkg and the macros of time_of_day_clock_with_alarm_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "time_of_day_clock_with_alarm_core_assert.svh"

module tod_checker
  import tod_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire tod_req_t in_req_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire tod_res_t out_res_o
);

  logic hour_ok;
  logic time_ok;
  logic flags_ok;
  logic in_held;
  logic out_held;

  // 12-hour dial and pm flag agree with the 24-hour value
  assign hour_ok = (out_res_o.show_hour12 == to_hour12(out_res_o.show_hour24)) &&
                   (out_res_o.is_pm == (out_res_o.show_hour24 >= HalfDay));
  assign time_ok = hour_ok && (out_res_o.show_hour24 <= LastHour) &&
                   (out_res_o.show_minute <= LastMinute) &&
                   (out_res_o.show_second <= LastSecond);

  // the latch only sets on a programmed alarm, the LED only on a set latch
  assign flags_ok = (!out_res_o.alarm_fired || out_res_o.alarm_armed) &&
                    (!out_res_o.alarm_led || out_res_o.alarm_fired);

  // transactions waiting on a stall
  assign in_held  = in_valid_i && in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  // a stalled result transaction stays offered and unchanged
  `TOD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_res_o), "stalled result changed")

  // a stalled request transaction stays offered and unchanged
  `TOD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_held, in_valid_i && $stable(in_req_i), "stalled request changed")

  // time fields in range and hour views consistent
  `TOD_ASSERT_SAME(a_time_ok, clk_i, rst_ni, out_valid_o, time_ok, "time fields inconsistent")

  // alarm flags consistent
  `TOD_ASSERT_SAME(a_alarm_flags, clk_i, rst_ni, out_valid_o, flags_ok, "alarm flags inconsistent")

  // with the result register empty the input is never stalled
  `TOD_ASSERT_SAME(a_in_free, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled while empty")

endmodule

bind time_of_day_clock_with_alarm_core tod_checker u_tod_checker (.*);

`default_nettype wire
